// File: hdl/uartrf_pkg.sv
package uartrf_pkg;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_LINE_RX = 2'd2,
        OP_LINE_TX = 2'd3
    } opcode_t;

    // register offsets
    localparam logic [2:0] REG_DATA = 3'd0;  // RBR / THR, DLL under DLAB
    localparam logic [2:0] REG_IER  = 3'd1;  // DLM under DLAB
    localparam logic [2:0] REG_IIR  = 3'd2;  // FCR on write
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;
    localparam logic [2:0] REG_SCR  = 3'd7;

    localparam int LCR_DLAB    = 7;
    localparam int LSR_DR      = 0;
    localparam int LSR_OE      = 1;
    localparam int LSR_THRE    = 5;
    localparam int LSR_TEMT    = 6;
    localparam int FCR_ENABLE  = 0;
    localparam int FCR_RX_CLR  = 1;
    localparam int FCR_TX_CLR  = 2;
    localparam int IER_BITS    = 4;
    localparam int MCR_BITS    = 5;

    localparam logic [7:0] IIR_NO_INT  = 8'h01;
    localparam logic [7:0] IIR_FIFO_ON = 8'hC0;
    localparam logic [7:0] DLL_RESET   = 8'h01;

    typedef struct packed {
        opcode_t    opcode;
        logic [2:0] address;
        logic [7:0] write_data;
        logic [7:0] line_byte;
    } item_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } result_t;

endpackage

// File: hdl/uartrf_fifo.sv
module uartrf_fifo import uartrf_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  fifo_cmd_t     cmd,
    input  logic [7:0]    push_data,
    output logic [CW-1:0] count,
    output logic [7:0]    head_data
);

    localparam int SW = IW + 1;

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    head_data_reg;
    logic [7:0]    mem [DEPTH];
    logic [SW-1:0] tail_sum;
    logic [IW-1:0] tail;

    // write slot: head + count, wrapped once
    always_comb begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= SW'(DEPTH)) begin
            tail_sum = tail_sum - SW'(DEPTH);
        end
        tail = tail_sum[IW-1:0];
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            head_next  = '0;
            count_next = '0;
        end else if (cmd.push) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop) begin
            head_next  = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // prefetch the word at the next head, bypassing a write to the same slot
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail] <= push_data;
        end
        head_data_reg <= (cmd.push && tail == head_next) ? push_data : mem[head_next];
    end

    assign count     = count_reg;
    assign head_data = head_data_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fifo count above depth");

    a_single_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.push, cmd.pop, cmd.clear}))
        else $error("more than one fifo command in a cycle");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> count_reg == '0)
        else $error("fifo not empty after clear");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> count_reg != '0)
        else $error("pop from empty fifo");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> count_reg < CW'(DEPTH))
        else $error("push into full fifo");
`endif

endmodule

// File: hdl/uartrf_regs.sv
module uartrf_regs import uartrf_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          item_valid,
    input  item_t         item,
    input  logic [CW-1:0] rx_count,
    input  logic [CW-1:0] tx_count,
    input  logic [7:0]    rx_head_data,
    input  logic [7:0]    tx_head_data,
    output fifo_cmd_t     rx_cmd,
    output fifo_cmd_t     tx_cmd,
    output result_t       result,
    output logic [15:0]   baud_divisor,
    output logic [7:0]    line_control,
    output logic [7:0]    modem_control
);

    logic [7:0]          dll_reg, dll_next;
    logic [7:0]          dlm_reg, dlm_next;
    logic [IER_BITS-1:0] ier_reg, ier_next;
    logic [7:0]          lcr_reg, lcr_next;
    logic [MCR_BITS-1:0] mcr_reg, mcr_next;
    logic [7:0]          scr_reg, scr_next;
    logic                fifo_en_reg, fifo_en_next;
    logic                overrun_reg, overrun_next;

    logic       dlab;
    logic       rx_full;
    logic       tx_full;
    logic       tx_empty;
    logic       mode_change;
    logic [7:0] lsr;

    always_comb begin
        dlab        = lcr_reg[LCR_DLAB];
        rx_full     = fifo_en_reg ? (rx_count == CW'(DEPTH)) : (rx_count != '0);
        tx_full     = fifo_en_reg ? (tx_count == CW'(DEPTH)) : (tx_count != '0);
        tx_empty    = (tx_count == '0);
        mode_change = item.write_data[FCR_ENABLE] != fifo_en_reg;

        lsr           = '0;
        lsr[LSR_DR]   = (rx_count != '0);
        lsr[LSR_OE]   = overrun_reg;
        lsr[LSR_THRE] = tx_empty;
        lsr[LSR_TEMT] = tx_empty;

        dll_next     = dll_reg;
        dlm_next     = dlm_reg;
        ier_next     = ier_reg;
        lcr_next     = lcr_reg;
        mcr_next     = mcr_reg;
        scr_next     = scr_reg;
        fifo_en_next = fifo_en_reg;
        overrun_next = overrun_reg;
        rx_cmd       = '0;
        tx_cmd       = '0;
        result       = '0;

        if (item_valid) begin
            unique case (item.opcode)
                OP_READ: begin
                    unique case (item.address)
                        REG_DATA: begin
                            if (dlab) begin
                                result.read_data = dll_reg;
                            end else if (rx_count != '0) begin
                                result.read_data = rx_head_data;
                                rx_cmd.pop       = 1'b1;
                            end
                        end
                        REG_IER: result.read_data = dlab ? dlm_reg : 8'(ier_reg);
                        REG_IIR: result.read_data = fifo_en_reg ? (IIR_NO_INT | IIR_FIFO_ON)
                                                                : IIR_NO_INT;
                        REG_LCR: result.read_data = lcr_reg;
                        REG_MCR: result.read_data = 8'(mcr_reg);
                        REG_LSR: begin
                            result.read_data = lsr;
                            overrun_next     = 1'b0;
                        end
                        REG_MSR: result.read_data = '0;
                        REG_SCR: result.read_data = scr_reg;
                    endcase
                end
                OP_WRITE: begin
                    unique case (item.address)
                        REG_DATA: begin
                            if (dlab) begin
                                dll_next = item.write_data;
                            end else if (tx_full) begin
                                overrun_next = 1'b1;
                            end else begin
                                tx_cmd.push = 1'b1;
                            end
                        end
                        REG_IER: begin
                            if (dlab) begin
                                dlm_next = item.write_data;
                            end else begin
                                ier_next = item.write_data[IER_BITS-1:0];
                            end
                        end
                        REG_IIR: begin
                            fifo_en_next = item.write_data[FCR_ENABLE];
                            rx_cmd.clear = mode_change || item.write_data[FCR_RX_CLR];
                            tx_cmd.clear = mode_change || item.write_data[FCR_TX_CLR];
                        end
                        REG_LCR: lcr_next = item.write_data;
                        REG_MCR: mcr_next = item.write_data[MCR_BITS-1:0];
                        REG_LSR, REG_MSR: ;
                        REG_SCR: scr_next = item.write_data;
                    endcase
                end
                OP_LINE_RX: begin
                    if (rx_full) begin
                        overrun_next = 1'b1;
                    end else begin
                        rx_cmd.push = 1'b1;
                    end
                end
                OP_LINE_TX: begin
                    if (!tx_empty) begin
                        tx_cmd.pop      = 1'b1;
                        result.tx_valid = 1'b1;
                        result.tx_byte  = tx_head_data;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dll_reg     <= DLL_RESET;
            dlm_reg     <= '0;
            ier_reg     <= '0;
            lcr_reg     <= '0;
            mcr_reg     <= '0;
            scr_reg     <= '0;
            fifo_en_reg <= 1'b0;
            overrun_reg <= 1'b0;
        end else begin
            dll_reg     <= dll_next;
            dlm_reg     <= dlm_next;
            ier_reg     <= ier_next;
            lcr_reg     <= lcr_next;
            mcr_reg     <= mcr_next;
            scr_reg     <= scr_next;
            fifo_en_reg <= fifo_en_next;
            overrun_reg <= overrun_next;
        end
    end

    assign baud_divisor  = {dlm_reg, dll_reg};
    assign line_control  = lcr_reg;
    assign modem_control = 8'(mcr_reg);

endmodule

// File: hdl/uart_register_file.sv
// Register side of a 16550-style UART.
// Input words (s_ channel) carry one event each: a bus read or write at
// offsets 0..7, a byte received from the line, or a request from the line
// transmitter for its next byte. The event kind travels in s_tuser.
// Every input word yields exactly one output word (m_ channel): the read
// byte, the byte handed to the transmitter (flagged by m_tuser), and the
// divisor, LCR, MCR and both FIFO levels as they stand after the event.
// Each accepted word is held in the input register, then processed into
// the result register, and its result is valid from then on.
// Throughput: one word per cycle while the receiver is ready; the FIFO
// pointers and control registers are updated by a single level of logic,
// and the byte at each FIFO head is prefetched from its memory into a register.
// Reset (aresetn low, synchronous) empties both FIFOs, drops any word in
// flight, loads the divisor with 1 and clears the other registers.
// If the receiver stalls, the result is held, one further input word is
// stored and then s_tready falls; no state changes until the result is taken.
module uart_register_file import uartrf_pkg::*; #(
    parameter int FIFO_DEPTH = 16,
    localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[2:0], write_data[10:3], line_byte[18:11], zero
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // read_data[7:0], tx_byte[15:8], baud_divisor[31:16],
                                   // line_control[39:32], modem_control[47:40],
                                   // rx_level[52:48], tx_level[57:53], zero
    output logic [0:0]  m_tuser    // tx_valid[0]
);

    logic          in_valid_reg;
    item_t         item_reg;
    logic          out_valid_reg;
    result_t       result_reg;
    logic          advance;

    fifo_cmd_t     rx_cmd, tx_cmd;
    result_t       result;
    logic [CW-1:0] rx_count, tx_count;
    logic [7:0]    rx_head_data, tx_head_data;
    logic [15:0]   baud_divisor;
    logic [7:0]    line_control;
    logic [7:0]    modem_control;

    // process the held word when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.opcode     <= opcode_t'(s_tuser);
            item_reg.address    <= s_tdata[2:0];
            item_reg.write_data <= s_tdata[10:3];
            item_reg.line_byte  <= s_tdata[18:11];
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    uartrf_regs #(.DEPTH(FIFO_DEPTH)) u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (advance),
        .item          (item_reg),
        .rx_count      (rx_count),
        .tx_count      (tx_count),
        .rx_head_data  (rx_head_data),
        .tx_head_data  (tx_head_data),
        .rx_cmd        (rx_cmd),
        .tx_cmd        (tx_cmd),
        .result        (result),
        .baud_divisor  (baud_divisor),
        .line_control  (line_control),
        .modem_control (modem_control)
    );

    uartrf_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (rx_cmd),
        .push_data (item_reg.line_byte),
        .count     (rx_count),
        .head_data (rx_head_data)
    );

    uartrf_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (tx_cmd),
        .push_data (item_reg.write_data),
        .count     (tx_count),
        .head_data (tx_head_data)
    );

    // state fields are live registers: they only move when a new result loads
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.tx_valid;
    assign m_tdata  = {6'b0, 5'(tx_count), 5'(rx_count), modem_control, line_control,
                       baud_divisor, result_reg.tx_byte, result_reg.read_data};

endmodule

// File: bench/tb_uart_register_file.sv
`timescale 1ns / 1ps

module tb_uart_register_file;
    import uartrf_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_STALL = 80;
    localparam int RX = 0;
    localparam int TX = 1;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [15:0] baud_divisor;
        logic [7:0]  line_control;
        logic [7:0]  modem_control;
        logic [4:0]  rx_level;
        logic [4:0]  tx_level;
    } reg_view_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // address[2:0], write_data[10:3], line_byte[18:11], zero
    logic [1:0]  s_tuser = '0;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // read_data, tx_byte, baud_divisor, line_control,
                                 // modem_control, rx_level, tx_level, zero
    logic [0:0]  m_tuser;        // tx_valid

    uart_register_file #(.FIFO_DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Shadow copy of the register file
    logic [7:0] fifo_mem [2][DEPTH];
    int         fifo_head [2] = '{0, 0};
    int         fifo_fill [2] = '{0, 0};
    logic [7:0] dll = DLL_RESET;
    logic [7:0] dlm = 8'h00;
    logic [7:0] ier = 8'h00;
    logic [7:0] lcr = 8'h00;
    logic [7:0] mcr = 8'h00;
    logic [7:0] scr = 8'h00;
    logic       fifo_on = 1'b0;
    logic [1:0] fifo_trig = 2'b00;
    logic       overrun = 1'b0;

    item_t     bus_events [$];
    reg_view_t pending_views [$];
    item_t     drv_word;

    logic calm = 1'b0;
    int   stall_req = 0;
    int   stall_seen = 0;
    int   stall_left = 0;

    int queued = 0;
    int faults = 0;
    int views_checked = 0;
    int op_seen [4] = '{0, 0, 0, 0};
    int bytes_dropped = 0;
    int overruns_reported = 0;
    int peak_fill [2] = '{0, 0};
    int idle_run;
    reg_view_t got;

    function automatic void fifo_flush(int f);
        fifo_head[f] = 0;
        fifo_fill[f] = 0;
    endfunction

    function automatic void fifo_push(int f, logic [7:0] b);
        if (fifo_fill[f] >= (fifo_on ? DEPTH : 1)) begin
            overrun = 1'b1;
            bytes_dropped++;
        end else begin
            fifo_mem[f][(fifo_head[f] + fifo_fill[f]) % DEPTH] = b;
            fifo_fill[f]++;
            if (fifo_fill[f] > peak_fill[f])
                peak_fill[f] = fifo_fill[f];
        end
    endfunction

    function automatic logic [7:0] fifo_pop(int f);
        logic [7:0] b;
        b = 8'h00;
        if (fifo_fill[f] != 0) begin
            b = fifo_mem[f][fifo_head[f]];
            fifo_head[f] = (fifo_head[f] + 1) % DEPTH;
            fifo_fill[f]--;
        end
        return b;
    endfunction

    // Apply one word to the shadow registers and return the view it yields
    function automatic reg_view_t register_file_step(item_t w);
        reg_view_t v;
        logic      dlab;
        v = '0;
        dlab = lcr[LCR_DLAB];
        case (w.opcode)
            OP_READ: begin
                case (w.address)
                    REG_DATA: v.read_data = dlab ? dll : fifo_pop(RX);
                    REG_IER:  v.read_data = dlab ? dlm : ier;
                    REG_IIR:  v.read_data = IIR_NO_INT | (fifo_on ? IIR_FIFO_ON : 8'h00);
                    REG_LCR:  v.read_data = lcr;
                    REG_MCR:  v.read_data = mcr;
                    REG_LSR: begin
                        v.read_data[LSR_DR]   = (fifo_fill[RX] != 0);
                        v.read_data[LSR_OE]   = overrun;
                        v.read_data[LSR_THRE] = (fifo_fill[TX] == 0);
                        v.read_data[LSR_TEMT] = (fifo_fill[TX] == 0);
                        if (overrun)
                            overruns_reported++;
                        overrun = 1'b0;
                    end
                    REG_MSR:  v.read_data = 8'h00;
                    default:  v.read_data = scr;
                endcase
            end
            OP_WRITE: begin
                case (w.address)
                    REG_DATA: begin
                        if (dlab)
                            dll = w.write_data;
                        else
                            fifo_push(TX, w.write_data);
                    end
                    REG_IER: begin
                        if (dlab)
                            dlm = w.write_data;
                        else
                            ier = w.write_data & 8'((1 << IER_BITS) - 1);
                    end
                    REG_IIR: begin
                        // a change of the enable bit empties both FIFOs
                        if (w.write_data[FCR_ENABLE] != fifo_on) begin
                            fifo_flush(RX);
                            fifo_flush(TX);
                        end
                        fifo_on = w.write_data[FCR_ENABLE];
                        if (w.write_data[FCR_RX_CLR])
                            fifo_flush(RX);
                        if (w.write_data[FCR_TX_CLR])
                            fifo_flush(TX);
                        fifo_trig = w.write_data[7:6];
                    end
                    REG_LCR: lcr = w.write_data;
                    REG_MCR: mcr = w.write_data & 8'((1 << MCR_BITS) - 1);
                    REG_SCR: scr = w.write_data;
                    default: ;
                endcase
            end
            OP_LINE_RX: fifo_push(RX, w.line_byte);
            default: begin
                if (fifo_fill[TX] != 0) begin
                    v.tx_valid = 1'b1;
                    v.tx_byte  = fifo_pop(TX);
                end
            end
        endcase
        v.baud_divisor  = {dlm, dll};
        v.line_control  = lcr;
        v.modem_control = mcr;
        v.rx_level      = 5'(fifo_fill[RX]);
        v.tx_level      = 5'(fifo_fill[TX]);
        return v;
    endfunction

    function automatic string view_str(reg_view_t v);
        return $sformatf("rd=%h txv=%b txb=%h div=%h lcr=%h mcr=%h rxl=%0d txl=%0d",
                         v.read_data, v.tx_valid, v.tx_byte, v.baud_divisor,
                         v.line_control, v.modem_control, v.rx_level, v.tx_level);
    endfunction

    // Sender: offer the next queued word, idling at random unless calm
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_views.push_back(register_file_step(drv_word));
                op_seen[drv_word.opcode]++;
            end
            if (!s_tvalid || s_tready) begin
                if (bus_events.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
                    drv_word = bus_events.pop_front();
                    s_tdata  <= {5'b0, drv_word.line_byte, drv_word.write_data,
                                 drv_word.address};
                    s_tuser  <= drv_word.opcode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: long hold-off on request, else random idling
    always @(posedge aclk) begin
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= LONG_STALL;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    // Compare each result word against the oldest expected view
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.read_data     = m_tdata[7:0];
            got.tx_byte       = m_tdata[15:8];
            got.baud_divisor  = m_tdata[31:16];
            got.line_control  = m_tdata[39:32];
            got.modem_control = m_tdata[47:40];
            got.rx_level      = m_tdata[52:48];
            got.tx_level      = m_tdata[57:53];
            got.tx_valid      = m_tuser[0];
            if (pending_views.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result word: %s", view_str(got));
            end else begin
                if (got !== pending_views[0]) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("mismatch on result %0d", views_checked);
                        $display("  expected %s", view_str(pending_views[0]));
                        $display("  actual   %s", view_str(got));
                    end
                end
                void'(pending_views.pop_front());
                views_checked++;
            end
        end
    end

    initial begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (bus_events.size() == 0 && !s_tvalid && pending_views.size() == 0))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [7:0] rbyte();
        return 8'($urandom);
    endfunction

    function automatic void queue_event(opcode_t op, logic [2:0] addr,
                                        logic [7:0] wd, logic [7:0] lb);
        item_t w;
        w.opcode     = op;
        w.address    = addr;
        w.write_data = wd;
        w.line_byte  = lb;
        bus_events.push_back(w);
        queued++;
    endfunction

    // Hold until every queued word has gone and every result has come back
    task automatic drain();
        do
            @(posedge aclk);
        while (bus_events.size() != 0 || s_tvalid || pending_views.size() != 0);
        @(negedge aclk);
    endtask

    task automatic add_random(int count);
        int goal;
        int pick;
        int n;
        logic [7:0] d;
        logic [2:0] a;
        goal = queued + count;
        while (queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // fill the receive side, then read it back
                n = $urandom_range(1, 20);
                repeat (n) queue_event(OP_LINE_RX, 3'($urandom), rbyte(), rbyte());
                if ($urandom_range(0, 1))
                    queue_event(OP_READ, REG_LSR, rbyte(), rbyte());
                n = $urandom_range(1, 20);
                repeat (n) queue_event(OP_READ, REG_DATA, rbyte(), rbyte());
            end else if (pick < 50) begin
                // load the transmit side, then let the line drain it
                n = $urandom_range(1, 20);
                repeat (n) queue_event(OP_WRITE, REG_DATA, rbyte(), rbyte());
                if ($urandom_range(0, 1))
                    queue_event(OP_READ, REG_LSR, rbyte(), rbyte());
                n = $urandom_range(1, 20);
                repeat (n) queue_event(OP_LINE_TX, 3'($urandom), rbyte(), rbyte());
            end else if (pick < 60) begin
                queue_event(OP_WRITE, REG_LCR, rbyte() | 8'h80, rbyte());
                queue_event(OP_WRITE, REG_DATA, rbyte(), rbyte());
                queue_event(OP_WRITE, REG_IER, rbyte(), rbyte());
                queue_event(OP_READ, REG_DATA, rbyte(), rbyte());
                queue_event(OP_READ, REG_IER, rbyte(), rbyte());
                queue_event(OP_WRITE, REG_LCR, rbyte() & 8'h7F, rbyte());
            end else if (pick < 70) begin
                // mostly keep the FIFOs on so the deep states stay reachable
                d = rbyte();
                d[FCR_ENABLE] = ($urandom_range(0, 9) != 0);
                queue_event(OP_WRITE, REG_IIR, d, rbyte());
                queue_event(OP_READ, REG_IIR, rbyte(), rbyte());
            end else if (pick < 85) begin
                case ($urandom_range(0, 5))
                    0:       a = REG_IER;
                    1:       a = REG_LCR;
                    2:       a = REG_MCR;
                    3:       a = REG_LSR;
                    4:       a = REG_MSR;
                    default: a = REG_SCR;
                endcase
                d = rbyte();
                if (a == REG_LCR && $urandom_range(0, 3) != 0)
                    d[LCR_DLAB] = 1'b0;
                queue_event(OP_WRITE, a, d, rbyte());
                queue_event(OP_READ, a, rbyte(), rbyte());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) queue_event(opcode_t'($urandom_range(0, 3)), 3'($urandom),
                                       rbyte(), rbyte());
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset values, holding registers, overrun, divisor, FIFO enable
        queue_event(OP_READ,    REG_DATA, 8'h00, 8'h00);
        queue_event(OP_READ,    REG_IIR,  8'h00, 8'h00);
        queue_event(OP_READ,    REG_MSR,  8'h00, 8'h00);
        queue_event(OP_WRITE,   REG_LSR,  8'hFF, 8'h00);
        queue_event(OP_LINE_TX, REG_DATA, 8'h00, 8'h00);
        queue_event(OP_WRITE,   REG_DATA, 8'hFF, 8'h00);
        queue_event(OP_WRITE,   REG_DATA, 8'h00, 8'h00);
        queue_event(OP_LINE_RX, REG_DATA, 8'h00, 8'hFF);
        queue_event(OP_LINE_RX, REG_DATA, 8'h00, 8'h00);
        queue_event(OP_READ,    REG_LSR,  8'h00, 8'h00);
        queue_event(OP_READ,    REG_LSR,  8'h00, 8'h00);
        queue_event(OP_READ,    REG_DATA, 8'h00, 8'h00);
        queue_event(OP_LINE_TX, REG_DATA, 8'h00, 8'h00);
        queue_event(OP_WRITE,   REG_IER,  8'hFF, 8'h00);
        queue_event(OP_READ,    REG_IER,  8'h00, 8'h00);
        queue_event(OP_WRITE,   REG_MCR,  8'hFF, 8'h00);
        queue_event(OP_READ,    REG_MCR,  8'h00, 8'h00);
        queue_event(OP_WRITE,   REG_LCR,  8'h83, 8'h00);
        queue_event(OP_WRITE,   REG_DATA, 8'hFF, 8'h00);
        queue_event(OP_WRITE,   REG_IER,  8'hFF, 8'h00);
        queue_event(OP_READ,    REG_DATA, 8'h00, 8'h00);
        queue_event(OP_READ,    REG_IER,  8'h00, 8'h00);
        queue_event(OP_WRITE,   REG_LCR,  8'h03, 8'h00);
        queue_event(OP_WRITE,   REG_IIR,  8'hC7, 8'h00);
        queue_event(OP_READ,    REG_IIR,  8'h00, 8'h00);
        drain();

        add_random(200);
        drain();

        calm = 1'b1;
        add_random(100);
        drain();

        // sender keeps offering while the receiver holds off
        stall_req = stall_req + 1;
        add_random(80);
        drain();

        calm = 1'b0;
        add_random(120);
        drain();
        repeat (8) @(posedge aclk);

        $display("checked %0d result words: %0d reads, %0d writes, %0d line rx, %0d line tx",
                 views_checked, op_seen[OP_READ], op_seen[OP_WRITE],
                 op_seen[OP_LINE_RX], op_seen[OP_LINE_TX]);
        $display("peak fill rx %0d / tx %0d, %0d bytes dropped, %0d overruns read from LSR",
                 peak_fill[RX], peak_fill[TX], bytes_dropped, overruns_reported);
        if (faults == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
